[rtl/core/aag_pkg.sv]
// Shared types and constants for the aperture amplitude generator.
// No dependencies; imported by aag_pow2 and the top level.
package aag_pkg;

    localparam int COORD_BITS      = 16;
    localparam int AMP_BITS        = 16;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 32;

    // exponent path widths: t < 16.0 kept in Q.20, u = t * log2(e) in Q.20
    localparam int FRAC_BITS       = 20;
    localparam int T20_BITS        = 24;
    localparam int U_BITS          = 25;
    localparam int N_BITS          = U_BITS - FRAC_BITS;
    localparam int TAB_BITS        = 25;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [AMP_BITS-1:0] AMP_FULL = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SHAPE_MODE      = 3'd0,
        REG_OUTER_RADIUS_SQ = 3'd1,
        REG_INNER_RADIUS_SQ = 3'd2,
        REG_HALF_WIDTH_X    = 3'd3,
        REG_HALF_WIDTH_Y    = 3'd4,
        REG_DECAY_SCALE     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_DISC    = 2'd0,
        MODE_RECT    = 2'd1,
        MODE_ANNULUS = 2'd2
    } shape_mode_t;

    // how the output stage forms the amplitude
    typedef enum logic [1:0] {
        AMP_ZERO,
        AMP_ONE,
        AMP_TAPER
    } amp_sel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
    } point_t;

    typedef struct packed {
        logic [AMP_BITS-1:0] amplitude;
        logic                inside_res;
    } result_t;

    // stage enables for the table lookup and interpolation stages
    typedef struct packed {
        logic rom_en;
        logic mul_en;
    } pow2_en_t;

endpackage

[rtl/core/aperture_amplitude_generator.sv]
// Aperture amplitude generator: disc, rectangle or Gaussian-tapered annulus.
// Depends on aag_pkg and aag_pow2.
//
// Usage:
//   point  : one grid point (x_coord, y_coord) per transfer, valid/stall.
//   result : amplitude in unsigned Q0.16 (1.0 saturates to 0xFFFF) and the
//            inside flag, one per point, same order, valid/stall.
//   cfg    : register writes, index and data, valid/ready; ready is always
//            high. Write only while no point is in flight.
// Timing:
//   Eight register stages, the last of them the output register. One point
//   per cycle sustained while the result side is not stalled; each
//   stage holds at most one 32x32 multiply or the registered table reads
//   of the 2^-x lookup, which set the stage depth.
// Reset:
//   Clears all stage valid bits and sets the registers to their defaults
//   (tapered annulus, all radii, widths and the decay scale zero).
// Stall:
//   Each stage moves when the one after it is empty or moving, so bubbles
//   close up; point_stall rises only when all eight stages are full.
module aperture_amplitude_generator
    import aag_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 64
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    output logic                      point_stall,
    input  point_t                    point,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int NSTAGE = 8;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int PROD_W = 64;
    localparam int UF_W   = T20_BITS + 31;

    // configuration registers
    logic [1:0]            shape_mode_reg;
    logic [31:0]           outer_radius_sq_reg;
    logic [31:0]           inner_radius_sq_reg;
    logic [COORD_BITS-1:0] half_width_x_reg;
    logic [COORD_BITS-1:0] half_width_y_reg;
    logic [31:0]           decay_scale_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_mode_reg      <= MODE_ANNULUS;
            outer_radius_sq_reg <= '0;
            inner_radius_sq_reg <= '0;
            half_width_x_reg    <= '0;
            half_width_y_reg    <= '0;
            decay_scale_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHAPE_MODE:      shape_mode_reg      <= cfg_data[1:0];
                REG_OUTER_RADIUS_SQ: outer_radius_sq_reg <= cfg_data;
                REG_INNER_RADIUS_SQ: inner_radius_sq_reg <= cfg_data;
                REG_HALF_WIDTH_X:    half_width_x_reg    <= cfg_data[COORD_BITS-1:0];
                REG_HALF_WIDTH_Y:    half_width_y_reg    <= cfg_data[COORD_BITS-1:0];
                REG_DECAY_SCALE:     decay_scale_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // pipeline control
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE-1:0] stage_en;

    always_comb
    begin
        stage_en[NSTAGE-1] = !vld_reg[NSTAGE-1] || !result_stall;
        for (int i = NSTAGE - 2; i >= 0; i--)
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (stage_en[0])
            vld_next[0] = point_valid;
        for (int i = 1; i < NSTAGE; i++)
            if (stage_en[i])
                vld_next[i] = vld_reg[i-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign point_stall  = !stage_en[0];
    assign result_valid = vld_reg[NSTAGE-1];

    // stage 0: magnitudes and rectangle test
    logic [COORD_BITS-1:0] ax_next;
    logic [COORD_BITS-1:0] ay_next;
    logic                  rect_next;
    logic [COORD_BITS-1:0] ax_reg;
    logic [COORD_BITS-1:0] ay_reg;
    logic                  rect0_reg;

    always_comb
    begin
        ax_next   = point.x_coord[COORD_BITS-1] ? (~point.x_coord + 1'b1) : point.x_coord;
        ay_next   = point.y_coord[COORD_BITS-1] ? (~point.y_coord + 1'b1) : point.y_coord;
        rect_next = (ax_next <= half_width_x_reg) && (ay_next <= half_width_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            rect0_reg <= rect_next;
        end
    end

    // stage 1: squares
    logic [SQ_W-1:0] sqx_reg;
    logic [SQ_W-1:0] sqy_reg;
    logic            rect1_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            sqx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
            sqy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
            rect1_reg <= rect0_reg;
        end
    end

    // stage 2: r^2 (at most 2^31, no carry out)
    logic [SQ_W-1:0] r2_reg;
    logic            rect2_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            r2_reg    <= sqx_reg + sqy_reg;
            rect2_reg <= rect1_reg;
        end
    end

    // stage 3: shape decision and t = r^2 * scale
    logic [PROD_W-1:0]   t_full;
    logic                disc_hit;
    logic                ring_hit;
    logic                inside3_next;
    amp_sel_t            sel3_next;
    logic [T20_BITS-1:0] t20_3_reg;
    logic                over3_reg;
    logic                inside3_reg;
    amp_sel_t            sel3_reg;

    always_comb
    begin
        t_full   = PROD_W'(r2_reg) * PROD_W'(decay_scale_reg);
        disc_hit = (r2_reg <= outer_radius_sq_reg);
        ring_hit = disc_hit && (r2_reg >= inner_radius_sq_reg);
        case (shape_mode_reg)
            MODE_DISC:
            begin
                inside3_next = disc_hit;
                sel3_next    = disc_hit ? AMP_ONE : AMP_ZERO;
            end
            MODE_RECT:
            begin
                inside3_next = rect2_reg;
                sel3_next    = rect2_reg ? AMP_ONE : AMP_ZERO;
            end
            MODE_ANNULUS:
            begin
                inside3_next = ring_hit;
                if (!ring_hit)
                    sel3_next = AMP_ZERO;
                else if (decay_scale_reg == '0)
                    sel3_next = AMP_ONE;
                else
                    sel3_next = AMP_TAPER;
            end
            default:
            begin
                inside3_next = 1'b0;
                sel3_next    = AMP_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            t20_3_reg   <= t_full[35:12];
            over3_reg   <= |t_full[PROD_W-1:36];
            inside3_reg <= inside3_next;
            sel3_reg    <= sel3_next;
        end
    end

    // stage 4: u = t * log2(e) in Q.20; t >= 16 gives zero amplitude
    logic [UF_W-1:0]   u_full;
    logic [U_BITS-1:0] u4_reg;
    logic              inside4_reg;
    amp_sel_t          sel4_reg;

    assign u_full = UF_W'(t20_3_reg) * UF_W'(LOG2E_Q30);

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            u4_reg      <= u_full[30 +: U_BITS];
            inside4_reg <= inside3_reg;
            sel4_reg    <= (sel3_reg == AMP_TAPER && over3_reg) ? AMP_ZERO : sel3_reg;
        end
    end

    // stages 5 and 6: 2^-u unit, side band follows alongside
    pow2_en_t            pow2_en;
    logic [AMP_BITS-1:0] taper_amp;
    logic                inside5_reg;
    amp_sel_t            sel5_reg;
    logic                inside6_reg;
    amp_sel_t            sel6_reg;

    assign pow2_en.rom_en = stage_en[5];
    assign pow2_en.mul_en = stage_en[6];

    aag_pow2 #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_pow2 (
        .clk    (clk),
        .en     (pow2_en),
        .u_int  (u4_reg[U_BITS-1:FRAC_BITS]),
        .u_frac (u4_reg[FRAC_BITS-1:0]),
        .amp    (taper_amp)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            inside5_reg <= inside4_reg;
            sel5_reg    <= sel4_reg;
        end
        if (stage_en[6])
        begin
            inside6_reg <= inside5_reg;
            sel6_reg    <= sel5_reg;
        end
    end

    // stage 7: output register
    result_t result_next;
    result_t result_reg;

    always_comb
    begin
        result_next.inside_res = inside6_reg;
        case (sel6_reg)
            AMP_ONE:   result_next.amplitude = AMP_FULL;
            AMP_TAPER: result_next.amplitude = taper_amp;
            default:   result_next.amplitude = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
            result_reg <= result_next;
    end

    assign result = result_reg;

    // checks
    a_no_stall_with_bubble: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(&vld_reg) |-> !point_stall)
        else $error("point stalled while a stage is empty");

    a_free_output_frees_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        !result_stall |-> !point_stall)
        else $error("point stalled while the result side is free");

    a_accept_fills_stage0: assert property (
        @(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall) |=> vld_reg[0])
        else $error("accepted point lost at the first stage");

    a_taper_only_inside: assert property (
        @(posedge clk) disable iff (!rst_n)
        (vld_reg[4] && sel4_reg == AMP_TAPER) |-> inside4_reg)
        else $error("tapered amplitude selected outside the shape");

    a_outside_is_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result.inside_res) |-> (result.amplitude == '0))
        else $error("nonzero amplitude outside the shape");

endmodule

[rtl/core/aag_pow2.sv]
// Two-stage 2^(-u) unit: table lookup with linear interpolation, then
// rounding shift by the integer part. Depends on aag_pkg.
module aag_pow2
    import aag_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 64
)(
    input  logic                 clk,
    input  pow2_en_t             en,
    input  logic [N_BITS-1:0]    u_int,
    input  logic [FRAC_BITS-1:0] u_frac,
    output logic [AMP_BITS-1:0]  amp
);

    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
    localparam int ADDR_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int P_W    = FRAC_BITS + IDX_W;
    localparam int MUL_W  = TAB_BITS + FRAC_BITS;
    localparam int SUM_W  = 33;
    localparam int SH_W   = 6;

    // round(2^(-k/D) * 2^24) from an alternating exp series in Q.32
    function automatic logic [TAB_BITS-1:0] pow2_entry(input int k);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        a    = (64'(k) * 64'(LN2_Q32)) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (int i = 1; i <= 20; i++)
        begin
            term = (term * a) >> 32;
            case (i)
                2:       term = term / 2;
                3:       term = term / 3;
                4:       term = term / 4;
                5:       term = term / 5;
                6:       term = term / 6;
                7:       term = term / 7;
                8:       term = term / 8;
                9:       term = term / 9;
                10:      term = term / 10;
                11:      term = term / 11;
                12:      term = term / 12;
                13:      term = term / 13;
                14:      term = term / 14;
                15:      term = term / 15;
                16:      term = term / 16;
                17:      term = term / 17;
                18:      term = term / 18;
                19:      term = term / 19;
                20:      term = term / 20;
                default: term = term;
            endcase
            if ((i & 1) != 0)
                neg = neg + term;
            else
                pos = pos + term;
        end
        r = (pos > neg) ? pos - neg : '0;
        r = (r + 64'd128) >> 8;
        if (r > (64'd1 << 24))
            r = 64'd1 << 24;
        return r[TAB_BITS-1:0];
    endfunction

    logic [TAB_BITS-1:0] pow2_rom [0:EXP_TABLE_DEPTH];

    for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++)
    begin : g_rom
        assign pow2_rom[k] = pow2_entry(k);
    end

    // lookup stage
    logic [P_W-1:0]       p;
    logic [ADDR_W-1:0]    hi_addr;
    logic [ADDR_W-1:0]    lo_addr;
    logic [TAB_BITS-1:0]  hi_a_reg;
    logic [TAB_BITS-1:0]  lo_a_reg;
    logic [FRAC_BITS-1:0] rem_a_reg;
    logic [FRAC_BITS-1:0] rem_a_next;
    logic [N_BITS-1:0]    n_a_reg;

    always_comb
    begin
        p          = P_W'(u_frac) * P_W'(EXP_TABLE_DEPTH);
        hi_addr    = ADDR_W'(p[P_W-1:FRAC_BITS]);
        lo_addr    = hi_addr + ADDR_W'(1);
        rem_a_next = p[FRAC_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.rom_en)
        begin
            hi_a_reg  <= pow2_rom[hi_addr];
            lo_a_reg  <= pow2_rom[lo_addr];
            rem_a_reg <= rem_a_next;
            n_a_reg   <= u_int;
        end
    end

    // interpolation stage
    logic [MUL_W-1:0]    step_full;
    logic [TAB_BITS-1:0] step_b_next;
    logic [TAB_BITS-1:0] step_b_reg;
    logic [TAB_BITS-1:0] hi_b_reg;
    logic [N_BITS-1:0]   n_b_reg;

    always_comb
    begin
        step_full   = MUL_W'(hi_a_reg - lo_a_reg) * MUL_W'(rem_a_reg);
        step_b_next = step_full[MUL_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en.mul_en)
        begin
            step_b_reg <= step_b_next;
            hi_b_reg   <= hi_a_reg;
            n_b_reg    <= n_a_reg;
        end
    end

    // round half up by 2^(n+8), saturate to full scale
    logic [TAB_BITS-1:0] v;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    scaled;

    always_comb
    begin
        v      = hi_b_reg - step_b_reg;
        sum    = SUM_W'(v) + (SUM_W'(1) << (SH_W'(n_b_reg) + SH_W'(7)));
        scaled = sum >> (SH_W'(n_b_reg) + SH_W'(8));
        amp    = (|scaled[SUM_W-1:AMP_BITS]) ? AMP_FULL : scaled[AMP_BITS-1:0];
    end

endmodule

[tb/aag_result_check.sv]
`timescale 1ns / 100ps
// Checker for the aperture amplitude generator: watches the point, result and
// cfg transfers, computes the expected amplitude and flag, and compares them.
// Depends on aag_pkg.
module aag_result_check
    import aag_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 64
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      point_valid,
    input  logic                      point_stall,
    input  point_t                    point,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  result_t                   result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        in_flight,
    output int                        mismatches
);

    logic [1:0]  mode_q;
    logic [31:0] outer_sq_q;
    logic [31:0] inner_sq_q;
    logic [15:0] half_x_q;
    logic [15:0] half_y_q;
    logic [31:0] decay_q;

    // 2^(-k/D) in Q.24, k = 0..D
    logic [31:0] pow2_lut [0:EXP_TABLE_DEPTH];
    result_t     due_results [$];

    bit      took;
    bit      gave;
    bit      popped;
    result_t want;

    function automatic logic [31:0] neg_exp2_entry(int k);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        a    = (64'(k) * LN2_Q32) / 64'(EXP_TABLE_DEPTH);
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        // alternating series for exp(-a), Q.32
        for (int i = 1; i <= 20; i++)
        begin
            term = ((term * a) >> 32) / 64'(i);
            if (i % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        r = (pos > neg) ? pos - neg : '0;
        r = (r + 64'd128) >> 8;
        if (r > (64'd1 << 24))
            r = 64'd1 << 24;
        return r[31:0];
    endfunction

    function automatic logic [COORD_BITS:0] magnitude(logic [COORD_BITS-1:0] c);
        logic [COORD_BITS:0] wrap;
        wrap = {1'b1, {COORD_BITS{1'b0}}};
        return c[COORD_BITS-1] ? wrap - {1'b0, c} : {1'b0, c};
    endfunction

    // exp(-r2 * decay) as 2^-u: shift for the integer part, table for the fraction
    function automatic logic [AMP_BITS-1:0] gaussian_taper(logic [63:0] r2);
        logic [63:0] lim;
        logic [63:0] t_q32;
        logic [63:0] t_q20;
        logic [63:0] u_q20;
        logic [63:0] n_int;
        logic [63:0] f_frac;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] rem;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] v;
        logic [63:0] amp;
        if (decay_q == '0)
            return AMP_FULL;
        lim = ((64'd16 << 32) + 64'(decay_q) - 64'd1) / 64'(decay_q);
        if (r2 >= lim)
            return '0;
        t_q32  = r2 * 64'(decay_q);
        t_q20  = t_q32 >> (32 - FRAC_BITS);
        u_q20  = (t_q20 * 64'(LOG2E_Q30)) >> 30;
        n_int  = u_q20 >> FRAC_BITS;
        f_frac = u_q20 & ((64'd1 << FRAC_BITS) - 64'd1);
        p      = f_frac * 64'(EXP_TABLE_DEPTH);
        idx    = p >> FRAC_BITS;
        rem    = p & ((64'd1 << FRAC_BITS) - 64'd1);
        if (idx >= 64'(EXP_TABLE_DEPTH))
        begin
            idx = 64'(EXP_TABLE_DEPTH - 1);
            rem = (64'd1 << FRAC_BITS) - 64'd1;
        end
        hi = 64'(pow2_lut[idx]);
        lo = 64'(pow2_lut[idx + 1]);
        v  = hi - (((hi - lo) * rem) >> FRAC_BITS);
        if (n_int > 64'd40)
            return '0;
        amp = (v + (64'd1 << (n_int + 7))) >> (n_int + 8);
        return (amp > 64'(AMP_FULL)) ? AMP_FULL : amp[AMP_BITS-1:0];
    endfunction

    function automatic result_t aperture_at(point_t p);
        logic [COORD_BITS:0] ax;
        logic [COORD_BITS:0] ay;
        logic [63:0]         r2;
        result_t             res;
        ax  = magnitude(p.x_coord);
        ay  = magnitude(p.y_coord);
        r2  = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        res = '0;
        case (mode_q)
            MODE_DISC:    res.inside_res = (r2 <= 64'(outer_sq_q));
            MODE_RECT:    res.inside_res = (ax <= half_x_q) && (ay <= half_y_q);
            MODE_ANNULUS: res.inside_res = (r2 <= 64'(outer_sq_q)) && (r2 >= 64'(inner_sq_q));
            default:      res.inside_res = 1'b0;   // spare mode: nothing is inside
        endcase
        if (res.inside_res)
            res.amplitude = (mode_q == MODE_ANNULUS) ? gaussian_taper(r2) : AMP_FULL;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input result_t exp_r, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected amplitude %0d inside %0b, got amplitude %0d inside %0b",
                     $time, what, exp_r.amplitude, exp_r.inside_res,
                     got.amplitude, got.inside_res);
    endtask

    initial
    begin
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++)
            pow2_lut[k] = neg_exp2_entry(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q     = MODE_ANNULUS;
            outer_sq_q = '0;
            inner_sq_q = '0;
            half_x_q   = '0;
            half_y_q   = '0;
            decay_q    = '0;
            mismatches = 0;
            due_results.delete();
            in_flight <= 0;
        end
        else
        begin
            took   = point_valid && !point_stall;
            gave   = result_valid && !result_stall;
            popped = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SHAPE_MODE:      mode_q     = cfg_data[1:0];
                    REG_OUTER_RADIUS_SQ: outer_sq_q = cfg_data;
                    REG_INNER_RADIUS_SQ: inner_sq_q = cfg_data;
                    REG_HALF_WIDTH_X:    half_x_q   = cfg_data[15:0];
                    REG_HALF_WIDTH_Y:    half_y_q   = cfg_data[15:0];
                    REG_DECAY_SCALE:     decay_q    = cfg_data;
                    default: ;   // unmapped index, dropped
                endcase
            end
            // pop before push so a same-edge point never matches its own result
            if (gave)
            begin
                if (due_results.size() == 0)
                    flag_mismatch("result with nothing pending", '0, result);
                else
                begin
                    want   = due_results.pop_front();
                    popped = 1'b1;
                    if (result.amplitude !== want.amplitude)
                        flag_mismatch("amplitude mismatch", want, result);
                    else if (result.inside_res !== want.inside_res)
                        flag_mismatch("inside flag mismatch", want, result);
                end
            end
            if (took)
                due_results.push_back(aperture_at(point));
            in_flight <= in_flight + int'(took) - int'(popped);
        end
    end

endmodule

[tb/tb_aperture_amplitude_generator.sv]
`timescale 1ns / 100ps
// Top of the aperture amplitude generator testbench: clock, reset, register
// setup, point stimulus and result backpressure. Depends on aag_pkg, the
// block itself and aag_result_check, which checks the results.
module tb_aperture_amplitude_generator;
    import aag_pkg::*;

    localparam int EXP_DEPTH        = 64;
    localparam int MAX_GAP          = 12;
    localparam int RAND_PHASES      = 14;
    localparam int PHASE_ITEMS      = 115;
    localparam int HOLD_PHASE       = 2;
    localparam int LONG_HOLD_CYCLES = 160;

    localparam logic [1:0]                MODE_UNUSED     = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                      clk;
    logic                      rst_n;
    logic                      point_valid;
    logic                      point_stall;
    point_t                    point;
    logic                      result_valid;
    logic                      result_stall;
    result_t                   result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        in_flight;
    int                        mismatches;

    bit tx_calm;
    bit hold_go;
    bit long_hold;

    aperture_amplitude_generator #(.EXP_TABLE_DEPTH(EXP_DEPTH)) uut (.*);

    aag_result_check #(.EXP_TABLE_DEPTH(EXP_DEPTH)) result_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic int rand_coord(int span);
        if (span >= 32768 || $urandom_range(0, 7) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // valid stays high from one transfer to the next unless a gap is drawn
    task automatic send_point(input int x, input int y);
        int     gap;
        point_t p;
        gap       = pick_gap(tx_calm);
        p.x_coord = 16'(x);
        p.y_coord = 16'(y);
        if (gap > 0)
        begin
            point_valid <= 1'b0;
            point       <= point_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        point       <= p;
        point_valid <= 1'b1;
        do @(posedge clk); while (point_stall);
    endtask

    task automatic settle();
        point_valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // narrow registers get junk in the unused upper data bits
    task automatic apply_setting(input logic [1:0] mode, input logic [31:0] outer,
                                 input logic [31:0] inner, input logic [15:0] hx,
                                 input logic [15:0] hy, input logic [31:0] decay);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_SHAPE_MODE, {junk[31:2], mode});
        write_reg(REG_OUTER_RADIUS_SQ, outer);
        write_reg(REG_UNMAPPED_LO, $urandom);
        write_reg(REG_INNER_RADIUS_SQ, inner);
        write_reg(REG_HALF_WIDTH_X, {junk[15:0], hx});
        write_reg(REG_HALF_WIDTH_Y, {junk[31:16], hy});
        write_reg(REG_DECAY_SCALE, decay);
        write_reg(REG_UNMAPPED_HI, $urandom);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : result_side
        int gap;
        int taken;
        bit calm;
        result_stall = 1'b0;
        gap          = 0;
        taken        = 0;
        calm         = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                taken++;
                if (taken % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                gap = pick_gap(calm);
            end
            else if (result_stall && gap > 0)
                gap--;
            result_stall <= long_hold || (gap > 0);
        end
    end

    // one long receiver hold so the pipe fills and stalls its input
    initial
    begin : long_hold_ctl
        long_hold = 1'b0;
        wait (hold_go);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    initial
    begin : stimulus
        int          span;
        int          sel;
        logic [63:0] r2_top;
        logic [63:0] r2_ref;
        logic [63:0] d64;
        logic [1:0]  mode;
        logic [31:0] outer;
        logic [31:0] inner;
        logic [31:0] decay;
        logic [15:0] hx;
        logic [15:0] hy;

        rst_n       = 1'b0;
        point_valid = 1'b0;
        point       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        tx_calm     = 1'b0;
        hold_go     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: annulus with zero radii and zero decay
        send_point(0, 0);
        send_point(1, 0);
        send_point(-32768, -32768);
        settle();

        apply_setting(MODE_ANNULUS, 32'h8000_0000, 32'd0, 16'd0, 16'd0, 32'h0010_0000);
        send_point(64, 0);
        send_point(-32768, -32768);
        send_point(0, 0);
        send_point(32767, -1);
        settle();

        // steepest decay: t reaches the cutoff within a few units
        apply_setting(MODE_ANNULUS, '1, 32'd0, 16'd0, 16'd0, '1);
        send_point(1, 0);
        send_point(4, 0);
        send_point(5, 0);
        send_point(0, 0);
        settle();

        apply_setting(MODE_RECT, 32'd0, 32'd0, 16'h8000, 16'h0000, 32'd0);
        send_point(-32768, 0);
        send_point(32767, 1);
        send_point(0, 0);
        settle();

        apply_setting(MODE_DISC, 32'd25, 32'd0, 16'd0, 16'd0, 32'd0);
        send_point(3, -4);
        send_point(5, 1);
        send_point(-32768, 32767);
        settle();

        // ring with a hole, flat amplitude
        apply_setting(MODE_ANNULUS, 32'd100, 32'd25, 16'd0, 16'd0, 32'd0);
        send_point(-5, 0);
        send_point(4, 0);
        send_point(0, -10);
        settle();

        // hole larger than the ring: empty
        apply_setting(MODE_ANNULUS, 32'd50, 32'd100, 16'd0, 16'd0, 32'd1);
        send_point(7, 0);
        send_point(0, 10);
        settle();

        apply_setting(MODE_UNUSED, '1, 32'd0, 16'hFFFF, 16'hFFFF, '1);
        send_point(0, 0);
        send_point(1, 1);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            span   = 1 << $urandom_range(0, 15);
            r2_top = 64'(2) * 64'(span) * 64'(span);

            sel = $urandom_range(0, 9);
            if (sel < 3)
                mode = MODE_DISC;
            else if (sel < 5)
                mode = MODE_RECT;
            else if (sel < 9)
                mode = MODE_ANNULUS;
            else
                mode = MODE_UNUSED;

            case ($urandom_range(0, 7))
                0:       outer = '0;
                1:       outer = 32'h8000_0000;
                2:       outer = '1;
                default: outer = $urandom_range(0, 32'(r2_top));
            endcase

            case ($urandom_range(0, 5))
                0:       inner = '0;
                1:       inner = outer + $urandom_range(1, 1000);
                default: inner = $urandom_range(0, outer >> 1);
            endcase

            case ($urandom_range(0, 5))
                0:       hx = '0;
                1:       hx = 16'h8000;
                2:       hx = '1;
                default: hx = 16'($urandom_range(0, span));
            endcase
            case ($urandom_range(0, 5))
                0:       hy = '0;
                1:       hy = 16'h8000;
                2:       hy = '1;
                default: hy = 16'($urandom_range(0, span));
            endcase

            // mostly scale the decay so t spans 0..24 across the ring
            r2_ref = (outer == '0 || 64'(outer) > r2_top) ? r2_top : 64'(outer);
            d64    = (64'($urandom_range(0, 24)) << 32) / r2_ref;
            case ($urandom_range(0, 7))
                0:       decay = '0;
                1:       decay = '1;
                2:       decay = $urandom;
                default: decay = (d64 > 64'hFFFF_FFFF) ? '1 : d64[31:0];
            endcase

            apply_setting(mode, outer, inner, hx, hy, decay);
            tx_calm = (ph == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE)
                hold_go = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_point(rand_coord(span), rand_coord(span));
            settle();
        end

        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
